// ----- rtl/core/bpc_pkg.sv -----
// Package: shared types, widths and register indexes for the barometer compensation block.
`default_nettype none

package bpc_pkg;

  localparam int unsigned CAL_W      = 16;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned TEMP_W     = 19;
  localparam int unsigned PRESS_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NUM_STAGES = 10;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

  // Output saturation bounds, held in the 20-bit internal temperature
  localparam logic signed [19:0] TEMP_REF = 20'sd2000;
  localparam logic signed [19:0] TEMP_MAX = 20'sd262143;
  localparam logic signed [19:0] TEMP_MIN = -20'sd262144;

  typedef logic [CAL_W-1:0]          cal_word_t;
  typedef logic [RAW_W-1:0]          raw_t;
  typedef logic signed [TEMP_W-1:0]  temp_t;
  typedef logic signed [PRESS_W-1:0] press_t;

  typedef struct packed {
    cal_word_t c1;
    cal_word_t c2;
    cal_word_t c3;
    cal_word_t c4;
    cal_word_t c5;
    cal_word_t c6;
  } cal_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpc_in_if.sv -----
// Interface: raw conversion pair channel (D1, D2) with valid/ready.
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;

  logic valid;
  logic ready;
  raw_t raw_pressure;
  raw_t raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/bpc_out_if.sv -----
// Interface: compensated result channel with valid/ready.
`default_nettype none

interface bpc_out_if;
  import bpc_pkg::*;

  logic   valid;
  logic   ready;
  temp_t  temperature_centi;
  press_t pressure_centi_mbar;
  logic   second_order_used;

  modport source (output valid, output temperature_centi, output pressure_centi_mbar,
                  output second_order_used, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_centi_mbar,
                  input second_order_used, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/bpc_datapath.sv -----
// Ten-stage compensation datapath; each stage loads when its enable is high.
`default_nettype none

module bpc_datapath (
  input  wire logic                               clk_i,
  input  wire logic [bpc_pkg::NUM_STAGES-1:0]     en_i,
  input  wire bpc_pkg::cal_t                      cal_i,
  input  wire bpc_pkg::raw_t                      raw_pressure_i,
  input  wire bpc_pkg::raw_t                      raw_temperature_i,
  output bpc_pkg::temp_t                          temperature_centi_o,
  output bpc_pkg::press_t                         pressure_centi_mbar_o,
  output logic                                    second_order_used_o
);
  import bpc_pkg::*;

  // stage 0: dT
  logic signed [24:0] s0_dt_d, s0_dt_q;
  raw_t               s0_d1_q;
  // stage 1: products of dT
  logic signed [41:0] s1_p6_d, s1_p6_q, s1_p4_d, s1_p4_q, s1_p3_d, s1_p3_q;
  logic signed [49:0] s1_pdd_d, s1_pdd_q;
  raw_t               s1_d1_q;
  // stage 2: first-order terms
  logic signed [41:0] s2_qsum;
  logic signed [18:0] s2_q_d, s2_q_q;
  logic [17:0]        s2_t2_d, s2_t2_q;
  logic signed [39:0] s2_off_d, s2_off_q;
  logic signed [37:0] s2_sens_d, s2_sens_q;
  logic               s2_sec_q;
  raw_t               s2_d1_q;
  // stage 3: square of temperature difference, corrected temperature
  logic signed [37:0] s3_sq;
  logic [34:0]        s3_aux_q;
  logic signed [19:0] s3_temp_d, s3_temp_q;
  logic signed [39:0] s3_off_q;
  logic signed [37:0] s3_sens_q;
  logic               s3_sec_q;
  raw_t               s3_d1_q;
  // stage 4: 5 * square
  logic [37:0]        s4_aux5_d, s4_aux5_q;
  logic signed [19:0] s4_temp_q;
  logic signed [39:0] s4_off_q;
  logic signed [37:0] s4_sens_q;
  logic               s4_sec_q;
  raw_t               s4_d1_q;
  // stage 5: final OFF and SENS
  logic signed [39:0] s5_off_d, s5_off_q;
  logic signed [37:0] s5_sens_d, s5_sens_q;
  logic signed [19:0] s5_temp_q;
  logic               s5_sec_q;
  raw_t               s5_d1_q;
  // stage 6: partial products of D1 * SENS
  logic [42:0]        s6_lo_d, s6_lo_q;
  logic signed [43:0] s6_hi_d, s6_hi_q;
  logic signed [39:0] s6_off_q;
  logic signed [19:0] s6_temp_q;
  logic               s6_sec_q;
  // stage 7: full product
  logic signed [62:0] s7_prod_d, s7_prod_q;
  logic signed [39:0] s7_off_q;
  logic signed [19:0] s7_temp_q;
  logic               s7_sec_q;
  // stage 8: scaled product minus offset
  logic signed [42:0] s8_x_d, s8_x_q;
  logic signed [19:0] s8_temp_q;
  logic               s8_sec_q;
  // stage 9: output register
  logic signed [42:0] s9_ysum;
  press_t             s9_press_d, s9_press_q;
  temp_t              s9_temp_d, s9_temp_q;
  logic               s9_sec_q;

  always_comb begin
    s0_dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.c5, 8'd0});

    s1_p6_d  = s0_dt_q * $signed({1'b0, cal_i.c6});
    s1_p4_d  = s0_dt_q * $signed({1'b0, cal_i.c4});
    s1_p3_d  = s0_dt_q * $signed({1'b0, cal_i.c3});
    s1_pdd_d = s0_dt_q * s0_dt_q;

    // divide by 2^23 truncating toward zero
    s2_qsum   = s1_p6_q + (s1_p6_q[41] ? 42'sd8388607 : 42'sd0);
    s2_q_d    = s2_qsum[41:23];
    s2_t2_d   = s1_pdd_q[48:31];
    s2_off_d  = $signed({8'd0, cal_i.c2, 16'd0})
              + $signed({{5{s1_p4_q[41]}}, s1_p4_q[41:7]});
    s2_sens_d = $signed({7'd0, cal_i.c1, 15'd0})
              + $signed({{4{s1_p3_q[41]}}, s1_p3_q[41:8]});

    s3_sq     = s2_q_q * s2_q_q;
    s3_temp_d = $signed({s2_q_q[18], s2_q_q}) + TEMP_REF
              - $signed({2'b00, s2_t2_q & {18{s2_sec_q}}});

    s4_aux5_d = {3'd0, s3_aux_q} + {1'b0, s3_aux_q, 2'b00};

    s5_off_d  = s4_off_q  - $signed({3'd0, s4_aux5_q[37:1]} & {40{s4_sec_q}});
    s5_sens_d = s4_sens_q - $signed({2'd0, s4_aux5_q[37:2]} & {38{s4_sec_q}});

    s6_lo_d = s5_d1_q * s5_sens_q[18:0];
    s6_hi_d = $signed({1'b0, s5_d1_q}) * $signed(s5_sens_q[37:19]);

    s7_prod_d = $signed({s6_hi_q, 19'd0}) + $signed({20'd0, s6_lo_q});

    s8_x_d = $signed({s7_prod_q[62], s7_prod_q[62:21]}) - $signed({{3{s7_off_q[39]}}, s7_off_q});

    // divide by 2^15 truncating toward zero; magnitude stays far inside 32 bits
    s9_ysum    = s8_x_q + (s8_x_q[42] ? 43'sd32767 : 43'sd0);
    s9_press_d = {{4{s9_ysum[42]}}, s9_ysum[42:15]};

    priority if (s8_temp_q > TEMP_MAX) begin
      s9_temp_d = TEMP_MAX[18:0];
    end else if (s8_temp_q < TEMP_MIN) begin
      s9_temp_d = TEMP_MIN[18:0];
    end else begin
      s9_temp_d = s8_temp_q[18:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_dt_q <= s0_dt_d;
      s0_d1_q <= raw_pressure_i;
    end
    if (en_i[1]) begin
      s1_p6_q  <= s1_p6_d;
      s1_p4_q  <= s1_p4_d;
      s1_p3_q  <= s1_p3_d;
      s1_pdd_q <= s1_pdd_d;
      s1_d1_q  <= s0_d1_q;
    end
    if (en_i[2]) begin
      s2_q_q    <= s2_q_d;
      s2_sec_q  <= s2_q_d[18];
      s2_t2_q   <= s2_t2_d;
      s2_off_q  <= s2_off_d;
      s2_sens_q <= s2_sens_d;
      s2_d1_q   <= s1_d1_q;
    end
    if (en_i[3]) begin
      s3_aux_q  <= s3_sq[34:0];
      s3_temp_q <= s3_temp_d;
      s3_off_q  <= s2_off_q;
      s3_sens_q <= s2_sens_q;
      s3_sec_q  <= s2_sec_q;
      s3_d1_q   <= s2_d1_q;
    end
    if (en_i[4]) begin
      s4_aux5_q <= s4_aux5_d;
      s4_temp_q <= s3_temp_q;
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_sec_q  <= s3_sec_q;
      s4_d1_q   <= s3_d1_q;
    end
    if (en_i[5]) begin
      s5_off_q  <= s5_off_d;
      s5_sens_q <= s5_sens_d;
      s5_temp_q <= s4_temp_q;
      s5_sec_q  <= s4_sec_q;
      s5_d1_q   <= s4_d1_q;
    end
    if (en_i[6]) begin
      s6_lo_q   <= s6_lo_d;
      s6_hi_q   <= s6_hi_d;
      s6_off_q  <= s5_off_q;
      s6_temp_q <= s5_temp_q;
      s6_sec_q  <= s5_sec_q;
    end
    if (en_i[7]) begin
      s7_prod_q <= s7_prod_d;
      s7_off_q  <= s6_off_q;
      s7_temp_q <= s6_temp_q;
      s7_sec_q  <= s6_sec_q;
    end
    if (en_i[8]) begin
      s8_x_q    <= s8_x_d;
      s8_temp_q <= s7_temp_q;
      s8_sec_q  <= s7_sec_q;
    end
    if (en_i[9]) begin
      s9_press_q <= s9_press_d;
      s9_temp_q  <= s9_temp_d;
      s9_sec_q   <= s8_sec_q;
    end
  end

  assign temperature_centi_o   = s9_temp_q;
  assign pressure_centi_mbar_o = s9_press_q;
  assign second_order_used_o   = s9_sec_q;

endmodule

`default_nettype wire

// ----- rtl/core/baro_pressure_temp_compensation_top.sv -----
// Top level: calibration registers, pipeline flow control and the compensation datapath.
`default_nettype none

// Takes one raw pressure/temperature conversion pair per transfer and returns the
// compensated temperature (0.01 C) and pressure (0.01 mbar), plus a flag for the
// low-temperature second-order correction. The datapath is a ten-stage pipeline: the
// input transfer loads stage 0, result valid rises when the pair reaches stage 9, and
// the output transfer waits until the output side is ready; a new pair can be taken
// every cycle unless back pressure holds stage 0. The longest arithmetic, D1 * SENS, is
// split into two partial products and a recombining add over two stages. Back pressure
// collapses bubbles first; a stage only holds when it and every stage after it are full.
// Calibration words C1..C6 sit at register indexes 0..5 and are 16 bits wide; indexes
// 6 and 7 are ignored. Write them only while no item is in flight.

module baro_pressure_temp_compensation_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bpc_pkg::CAL_W-1:0]     cfg_wdata_i,
  bpc_in_if.sink                             meas_i,
  bpc_out_if.source                          result_o
);
  import bpc_pkg::*;

  cal_t                  cal_q;
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;

  // a stage loads when empty or when the stage after it moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= meas_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_C1:  cal_q.c1 <= cfg_wdata_i;
        REG_C2:  cal_q.c2 <= cfg_wdata_i;
        REG_C3:  cal_q.c3 <= cfg_wdata_i;
        REG_C4:  cal_q.c4 <= cfg_wdata_i;
        REG_C5:  cal_q.c5 <= cfg_wdata_i;
        REG_C6:  cal_q.c6 <= cfg_wdata_i;
        default: cal_q <= cal_q;
      endcase
    end
  end

  assign meas_i.ready   = en[0];
  assign result_o.valid = vld_q[NUM_STAGES-1];

  bpc_datapath u_datapath (
    .clk_i                 (clk_i),
    .en_i                  (en),
    .cal_i                 (cal_q),
    .raw_pressure_i        (meas_i.raw_pressure),
    .raw_temperature_i     (meas_i.raw_temperature),
    .temperature_centi_o   (result_o.temperature_centi),
    .pressure_centi_mbar_o (result_o.pressure_centi_mbar),
    .second_order_used_o   (result_o.second_order_used)
  );

endmodule

`default_nettype wire

// ----- tb/sv/baro_pressure_temp_compensation_top_tb.sv -----
// Testbench: random and directed checking of the barometer compensation pipeline.
import bpc_pkg::*;

// Holds the calibration copy, predicts each compensated result and checks the output stream.
class compensation_scoreboard;
  localparam longint ROOM_CENTI   = 2000;
  localparam longint TEMP_SCALE   = 8388608;
  localparam longint PRESS_SCALE  = 32768;
  localparam longint OFF_GAIN     = 65536;
  localparam longint SENS_GAIN    = 32768;
  localparam longint RAW_REF_GAIN = 256;
  localparam longint SECOND_GAIN  = 5;
  localparam longint TEMP_FLOOR   = -262144;
  localparam longint TEMP_CEIL    = 262143;
  localparam longint PRESS_FLOOR  = -64'sd2147483648;
  localparam longint PRESS_CEIL   = 64'sd2147483647;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    temp_t  temperature;
    press_t pressure;
    logic   second_order;
  } comp_result_t;

  comp_result_t due_q[$];
  cal_t         cal;
  int unsigned  mismatches;

  function new();
    cal = '0;
    mismatches = 0;
  endfunction

  function void write_cal(logic [CFG_IDX_W-1:0] idx, cal_word_t value);
    case (idx)
      REG_C1: cal.c1 = value;
      REG_C2: cal.c2 = value;
      REG_C3: cal.c3 = value;
      REG_C4: cal.c4 = value;
      REG_C5: cal.c5 = value;
      REG_C6: cal.c6 = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  function void note_pair(raw_t d1, raw_t d2);
    longint dt, temp_c, offset, sens, tdiff, sq, press;
    comp_result_t r;
    dt     = longint'(d2) - longint'(cal.c5) * RAW_REF_GAIN;
    temp_c = ROOM_CENTI + (dt * longint'(cal.c6)) / TEMP_SCALE;
    offset = longint'(cal.c2) * OFF_GAIN + ((longint'(cal.c4) * dt) >>> 7);
    sens   = longint'(cal.c1) * SENS_GAIN + ((longint'(cal.c3) * dt) >>> 8);
    r.second_order = (temp_c < ROOM_CENTI);
    if (r.second_order) begin
      tdiff  = temp_c - ROOM_CENTI;
      sq     = tdiff * tdiff;
      temp_c = temp_c - ((dt * dt) >>> 31);
      offset = offset - ((SECOND_GAIN * sq) >>> 1);
      sens   = sens - ((SECOND_GAIN * sq) >>> 2);
    end
    press = (((longint'(d1) * sens) >>> 21) - offset) / PRESS_SCALE;
    if (temp_c < TEMP_FLOOR) temp_c = TEMP_FLOOR;
    if (temp_c > TEMP_CEIL) temp_c = TEMP_CEIL;
    if (press < PRESS_FLOOR) press = PRESS_FLOOR;
    if (press > PRESS_CEIL) press = PRESS_CEIL;
    r.temperature = temp_t'(temp_c);
    r.pressure    = press_t'(press);
    due_q.push_back(r);
  endfunction

  function void check_result(temp_t t, press_t p, logic f);
    comp_result_t want;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result: temp %0d press %0d second %0b", t, p, f);
      return;
    end
    want = due_q.pop_front();
    if (t !== want.temperature || p !== want.pressure || f !== want.second_order) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch: temp exp %0d got %0d, press exp %0d got %0d, second exp %0b got %0b",
                 want.temperature, t, want.pressure, p, want.second_order, f);
    end
  endfunction
endclass

module baro_pressure_temp_compensation_top_tb;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 124;
  localparam raw_t RAW_MAX = '1;
  localparam cal_t TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                   c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  cal_word_t            cfg_wdata_i;

  bpc_in_if  meas_if ();
  bpc_out_if res_if ();

  compensation_scoreboard sb = new();
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int idle_cycles;

  baro_pressure_temp_compensation_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .meas_i      (meas_if),
    .result_o    (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cal_word_t random_cal_word(bit realistic);
    int r;
    if (realistic) return cal_word_t'($urandom_range(20000, 50000));
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return cal_word_t'($urandom_range(0, 65535));
  endfunction

  function automatic raw_t edge_raw();
    int k;
    k = $urandom_range(0, RAW_W - 1);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return raw_t'(1) << k;
      default: return ~(raw_t'(1) << k);
    endcase
  endfunction

  // Nearly half the pairs sit near the reference temperature so both sides of 20.00 C get hit.
  task automatic pick_pair(output raw_t d1, output raw_t d2);
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      t = int'(sb.cal.c5) * 256 + int'($urandom_range(0, 4194304)) - 2097152;
      if (t < 0) t = 0;
      if (t > int'(RAW_MAX)) t = int'(RAW_MAX);
      d1 = raw_t'($urandom_range(0, int'(RAW_MAX)));
      d2 = raw_t'(t);
    end else if (r < 60) begin
      d1 = edge_raw();
      d2 = edge_raw();
    end else begin
      d1 = raw_t'($urandom_range(0, int'(RAW_MAX)));
      d2 = raw_t'($urandom_range(0, int'(RAW_MAX)));
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cal_word_t value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_cal(idx, value);
  endtask

  // Spare indexes get junk too; the block must drop those writes.
  task automatic program_cal(cal_t c);
    write_reg(REG_SPARE_LO, cal_word_t'($urandom_range(0, 65535)));
    write_reg(REG_C1, c.c1);
    write_reg(REG_C2, c.c2);
    write_reg(REG_C3, c.c3);
    write_reg(REG_C4, c.c4);
    write_reg(REG_C5, c.c5);
    write_reg(REG_C6, c.c6);
    write_reg(REG_SPARE_HI, cal_word_t'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pair(raw_t d1, raw_t d2);
    meas_if.valid           <= 1'b1;
    meas_if.raw_pressure    <= d1;
    meas_if.raw_temperature <= d2;
    do @(posedge clk_i); while (!meas_if.ready);
    sb.note_pair(d1, d2);
  endtask

  task automatic pace_sender();
    int g;
    if (tx_steady) return;
    g = gap_len();
    if (g > 0) begin
      meas_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    meas_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_random_phase(int p);
    cal_t c;
    raw_t d1;
    raw_t d2;
    bit   realistic;
    realistic = (p % 3 == 0);
    c.c1 = random_cal_word(realistic);
    c.c2 = random_cal_word(realistic);
    c.c3 = random_cal_word(realistic);
    c.c4 = random_cal_word(realistic);
    c.c5 = random_cal_word(realistic);
    c.c6 = random_cal_word(realistic);
    program_cal(c);
    tx_steady = (p % 4 == 1);
    rx_steady = (p % 4 == 1) || (p % 5 == 3);
    if (p == 2) begin
      // long output stall with a steady feed: pipeline fills and back-pressures the input
      tx_steady = 1'b1;
      hold_req  = 1'b1;
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (p == 5 && i == PHASE_ITEMS / 2) drain_results();
      pick_pair(d1, d2);
      send_pair(d1, d2);
      pace_sender();
    end
    drain_results();
  endtask

  // output side: random back-pressure, steady stretches, one long hold on request
  initial begin
    int g;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_steady) begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        g = gap_len();
        if (g > 0) begin
          res_if.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.temperature_centi, res_if.pressure_centi_mbar,
                      res_if.second_order_used);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((meas_if.valid && meas_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("baro_pressure_temp_compensation_top_tb: errors");
    $finish;
  end

  initial begin
    int ref_raw;
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = REG_C1;
    cfg_wdata_i             = '0;
    meas_if.valid           = 1'b0;
    meas_if.raw_pressure    = '0;
    meas_if.raw_temperature = '0;
    tx_steady               = 1'b0;
    rx_steady               = 1'b0;
    hold_req                = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // calibration still at reset: all zero
    send_pair('0, '0);        pace_sender();
    send_pair(RAW_MAX, RAW_MAX); pace_sender();
    send_pair(RAW_MAX, '0);   pace_sender();
    send_pair('0, RAW_MAX);
    drain_results();

    // typical calibration: nominal point, 20.00 C boundary, truncation, deep cold
    program_cal(TYPICAL_CAL);
    ref_raw = int'(TYPICAL_CAL.c5) * 256;
    send_pair(raw_t'(9085466), raw_t'(8569150)); pace_sender();
    send_pair('0, '0);                            pace_sender();
    send_pair(RAW_MAX, RAW_MAX);                  pace_sender();
    send_pair(RAW_MAX, raw_t'(ref_raw));          pace_sender();
    send_pair(raw_t'(9085466), raw_t'(ref_raw - 296)); pace_sender();
    send_pair(raw_t'(9085466), raw_t'(ref_raw - 297)); pace_sender();
    send_pair(raw_t'(9085466), raw_t'(ref_raw - 2000000)); pace_sender();
    send_pair('0, RAW_MAX);
    drain_results();

    // every calibration word at full scale
    program_cal('1);
    send_pair('0, '0);           pace_sender();
    send_pair(RAW_MAX, RAW_MAX); pace_sender();
    send_pair(RAW_MAX, '0);      pace_sender();
    send_pair('0, RAW_MAX);      pace_sender();
    send_pair(raw_t'(8388608), raw_t'(8388608));
    drain_results();

    for (int p = 0; p < RAND_PHASES; p++) run_random_phase(p);

    repeat (2 * NUM_STAGES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("baro_pressure_temp_compensation_top_tb: clean");
    else
      $display("baro_pressure_temp_compensation_top_tb: errors");
    $finish;
  end
endmodule
